// ===== rtl/dlfg_pkg.sv =====
// Shared types and constants for the delayed linear fade gain core.
// Used by dlfg_ctrl, dlfg_gain and delayed_linear_fade_gain_core.
package dlfg_pkg;

  localparam int BLOCK_SAMPLES = 128;
  localparam int IDX_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_SAMPLES - 1);

  localparam int POS_W    = 32;
  localparam int DELAY_W  = 31;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int CMD_W    = 2;

  localparam logic [DELAY_W-1:0] DELAY_STEP = DELAY_W'(BLOCK_SAMPLES);

  localparam logic [POS_W-1:0] POS_FULL     = 32'hFFFF_FFFF;
  localparam logic [POS_W-1:0] POS_ZERO     = 32'h0000_0000;
  localparam logic [POS_W-1:0] POS_IN_START = 32'h0000_0001;
  localparam logic [POS_W-1:0] POS_OUT_START = 32'hFFFF_FFFE;
  localparam logic [POS_W-1:0] RATE_RESET   = 32'h0001_0000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FADE_IN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FADE_OUT = 2'd2;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_FADE_RATE     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_SAMPLES = 1'b1;

  typedef enum logic [1:0] {
    MODE_PASS   = 2'd0,
    MODE_SILENT = 2'd1,
    MODE_FADE   = 2'd2
  } mode_t;

  // Word handed from the control stage to the gain stage
  typedef struct packed {
    mode_t                      mode;
    logic [GAIN_W-1:0]          gain;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
  } stage_t;

endpackage

// ===== rtl/delayed_linear_fade_gain_core.sv =====
// Top level of the delayed linear fade gain core.
// Depends on dlfg_pkg, dlfg_ctrl and dlfg_gain.
//
// Takes one word per cycle unless stalled, a rate set by the block/fade state update
// in the control stage: command 0 carries an audio sample and yields one result;
// commands 1 and 2 queue a fade in or fade out that takes effect at the next block
// boundary and yield nothing. A sample passes the stage register, then the result
// register behind the multiplier. Configuration writes are taken at any time but
// should be made while the core is idle.
module delayed_linear_fade_gain_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dlfg_pkg::CMD_W-1:0]           in_command,
  input  logic signed [dlfg_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dlfg_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                 out_fade_active,
  input  logic                                 cfg_we,
  input  logic [dlfg_pkg::CFG_ADDR_W-1:0]      cfg_index,
  input  logic [dlfg_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dlfg_pkg::*;

  logic   down_ready;
  logic   s1_valid;
  stage_t s1_word;

  dlfg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_sample_in (in_sample_in),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .down_ready   (down_ready),
    .s1_valid     (s1_valid),
    .s1_word      (s1_word)
  );

  dlfg_gain u_gain (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1_valid        (s1_valid),
    .s1_word         (s1_word),
    .down_ready      (down_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_out  (out_sample_out),
    .out_fade_active (out_fade_active)
  );

endmodule

// ===== rtl/dlfg_ctrl.sv =====
// Control stage: configuration registers, block/delay/fade state and the stage register.
// Depends on dlfg_pkg.
module dlfg_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dlfg_pkg::CMD_W-1:0]         in_command,
  input  logic signed [dlfg_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                               cfg_we,
  input  logic [dlfg_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  logic [dlfg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               down_ready,
  output logic                               s1_valid,
  output dlfg_pkg::stage_t                   s1_word
);
  import dlfg_pkg::*;

  logic [POS_W-1:0]   fade_rate_r;
  logic [DELAY_W-1:0] delay_samples_r;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               fade_up_r, fade_up_nxt;
  logic               target_up_r, target_up_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  mode_t              mode_r, mode_nxt;
  logic [CMD_W-1:0]   pend_r, pend_nxt;
  logic               active_r, active_nxt;

  logic   s1_valid_r, s1_valid_nxt;
  stage_t s1_r, s1_nxt;

  logic in_acc;
  logic load;

  assign in_stall = s1_valid_r && !down_ready;
  assign in_acc   = in_valid && !in_stall;
  assign load     = in_acc && (in_command == CMD_SAMPLE);

  always_comb begin
    pos_nxt       = pos_r;
    fade_up_nxt   = fade_up_r;
    target_up_nxt = target_up_r;
    delay_nxt     = delay_r;
    idx_nxt       = idx_r;
    mode_nxt      = mode_r;
    pend_nxt      = pend_r;
    active_nxt    = active_r;
    s1_nxt        = s1_r;

    if (in_acc && (in_command == CMD_FADE_IN || in_command == CMD_FADE_OUT)) begin
      pend_nxt = in_command;
    end else if (load) begin
      if (idx_r == '0) begin
        // Arm a pending start on the first word of the block
        if (pend_r != CMD_SAMPLE) begin
          target_up_nxt = (pend_r == CMD_FADE_IN);
          delay_nxt     = delay_samples_r;
          active_nxt    = 1'b1;
          pend_nxt      = CMD_SAMPLE;
          if (delay_samples_r == '0) begin
            fade_up_nxt = target_up_nxt;
            pos_nxt     = target_up_nxt ? POS_IN_START : POS_OUT_START;
          end
        end
        if (delay_nxt != '0) begin
          mode_nxt  = (pos_nxt == POS_FULL) ? MODE_PASS : MODE_SILENT;
          delay_nxt = (delay_nxt > DELAY_STEP) ? delay_nxt - DELAY_STEP : '0;
          if (delay_nxt == '0) begin
            fade_up_nxt = target_up_nxt;
            pos_nxt     = target_up_nxt ? POS_IN_START : POS_OUT_START;
          end
        end else if (pos_nxt == POS_ZERO) begin
          mode_nxt   = MODE_SILENT;
          active_nxt = 1'b0;
        end else if (pos_nxt == POS_FULL) begin
          mode_nxt   = MODE_PASS;
          active_nxt = 1'b0;
        end else begin
          mode_nxt = MODE_FADE;
        end
      end

      s1_nxt.mode   = mode_nxt;
      s1_nxt.gain   = pos_nxt[POS_W-1 -: GAIN_W];
      s1_nxt.sample = in_sample_in;
      s1_nxt.active = active_nxt;

      // Ramp the position after the gain is taken, saturating at either end
      if (mode_nxt == MODE_FADE) begin
        if (fade_up_nxt) begin
          pos_nxt = (fade_rate_r < ~pos_nxt) ? pos_nxt + fade_rate_r : POS_FULL;
        end else begin
          pos_nxt = (fade_rate_r < pos_nxt) ? pos_nxt - fade_rate_r : POS_ZERO;
        end
      end

      idx_nxt = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
    end
  end

  always_comb begin
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (down_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_rate_r     <= RATE_RESET;
      delay_samples_r <= '0;
      pos_r           <= POS_FULL;
      fade_up_r       <= 1'b0;
      target_up_r     <= 1'b0;
      delay_r         <= '0;
      idx_r           <= '0;
      mode_r          <= MODE_PASS;
      pend_r          <= CMD_SAMPLE;
      active_r        <= 1'b0;
      s1_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FADE_RATE:     fade_rate_r     <= cfg_data;
          CFG_DELAY_SAMPLES: delay_samples_r <= cfg_data[DELAY_W-1:0];
          default: ;
        endcase
      end
      pos_r       <= pos_nxt;
      fade_up_r   <= fade_up_nxt;
      target_up_r <= target_up_nxt;
      delay_r     <= delay_nxt;
      idx_r       <= idx_nxt;
      mode_r      <= mode_nxt;
      pend_r      <= pend_nxt;
      active_r    <= active_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_r;

  a_delay_implies_active: assert property (@(posedge clk) disable iff (!rst_n)
    (delay_r != '0) |-> active_r)
    else $error("delay pending while fade inactive");

  a_fade_word_active: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.mode == MODE_FADE) |-> s1_r.active)
    else $error("fading word without active flag");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !down_ready) |=> (s1_valid_r && $stable(s1_r)))
    else $error("stage word lost under stall");

endmodule

// ===== rtl/dlfg_gain.sv =====
// Gain stage: applies the gain to the staged word and holds the result register.
// Depends on dlfg_pkg.
module dlfg_gain (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 s1_valid,
  input  dlfg_pkg::stage_t                     s1_word,
  output logic                                 down_ready,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dlfg_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                 out_fade_active
);
  import dlfg_pkg::*;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                       active_r;
  logic signed [SAMPLE_W+GAIN_W:0] prod;

  assign down_ready = !out_valid_r || !out_stall;

  assign prod = (SAMPLE_W+GAIN_W+1)'(s1_word.sample) *
                (SAMPLE_W+GAIN_W+1)'($signed({1'b0, s1_word.gain}));

  always_comb begin
    case (s1_word.mode)
      MODE_SILENT: sample_nxt = '0;
      MODE_PASS:   sample_nxt = s1_word.sample;
      MODE_FADE:   sample_nxt = prod[SAMPLE_W+GAIN_W-1 -: SAMPLE_W];
      default:     sample_nxt = s1_word.sample;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (down_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (down_ready && s1_valid) begin
      sample_r <= sample_nxt;
      active_r <= s1_word.active;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = sample_r;
  assign out_fade_active = active_r;

  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && down_ready && s1_word.mode == MODE_SILENT) |=> (out_sample_out == '0))
    else $error("silent word produced nonzero sample");

  a_pass_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && down_ready && s1_word.mode == MODE_PASS)
      |=> (out_sample_out == $past(s1_word.sample)))
    else $error("pass-through word altered");

endmodule
